>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the supply monitor modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define TMSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define TMSM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TMSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define TMSM_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> hw/rtl/tmsm_pkg.sv
// ----------------------------------------------------------------------------
// tmsm_pkg
// shared types and constants of the trimmed mean supply monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmsm_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int BATCH_LEN       = 10;
    localparam int CNT_W           = 4;
    localparam int FILT_DIVISOR    = 10;

    // x / 10 as (x * ceil(2^23 / 10)) >> 23, exact for x below 2^22
    localparam int                      FILT_RECIP_W = 20;
    localparam logic [FILT_RECIP_W-1:0] FILT_RECIP   = 20'd838861;
    localparam int                      FILT_SHIFT   = 23;

    localparam int CFG_W    = 24;
    localparam int SCALE_W  = 24;
    localparam int MV_W     = 16;
    localparam int SPAN_W   = 8;
    localparam int PCT_W    = 7;

    localparam logic [SCALE_W-1:0] VDD_SCALE_RST  = 24'd4915200;
    localparam logic [MV_W-1:0]    EMPTY_MV_RST   = 16'd2800;
    localparam logic [SPAN_W-1:0]  MV_PER_PCT_RST = 8'd14;

    localparam logic [MV_W-1:0]  MV_MAX  = 16'hFFFF;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    localparam int DIV_DEND_W = 24;
    localparam int DIV_SOR_W  = 16;
    localparam int DIV_CNT_W  = 5;

    typedef enum logic [1:0] {
        CFG_VDD_SCALE  = 2'd0,
        CFG_EMPTY_MV   = 2'd1,
        CFG_MV_PER_PCT = 2'd2
    } cfg_addr_t;

    typedef enum logic {
        DIV_MV,
        DIV_PCT
    } div_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_FILT,
        ST_FILT_MUL,
        ST_MV,
        ST_MV_WAIT,
        ST_PCT,
        ST_PCT_WAIT,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic    batch_clear;
        logic    batch_add;
        logic    calc_mean;
        logic    load_mix;
        logic    div_start;
        div_op_t div_op;
        logic    load_filt_mean;
        logic    load_filt_div;
        logic    load_mv_sat;
        logic    load_mv_div;
        logic    load_pct_zero;
        logic    load_pct_div;
        logic    publish;
    } tmsm_cmd_t;

    typedef struct packed {
        logic last_sample;
        logic seeded;
        logic div_busy;
        logic div_done;
        logic filt_zero;
        logic mv_le_empty;
        logic out_free;
    } tmsm_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/tmsm_div.sv
// ----------------------------------------------------------------------------
// tmsm_div
// restoring divider, one quotient bit per cycle, shared by the millivolt and percent divisions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmsm_div
    import tmsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIV_DEND_W-1:0] dividend,
    input  wire logic [DIV_SOR_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [DIV_DEND_W-1:0]      quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_SOR_W-1:0]  rem_reg;
    logic [DIV_SOR_W-1:0]  dsr_reg;
    logic [DIV_DEND_W-1:0] quo_reg;

    logic [DIV_SOR_W:0]    shifted;
    logic [DIV_SOR_W+1:0]  diff;
    logic                  fits;
    logic [DIV_SOR_W-1:0]  rem_next;
    logic [DIV_DEND_W-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_DEND_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dsr_reg};
        fits     = ~diff[DIV_SOR_W+1];
        rem_next = fits ? diff[DIV_SOR_W-1:0] : shifted[DIV_SOR_W-1:0];
        quo_next = {quo_reg[DIV_DEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_DEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tmsm_ctrl.sv
// ----------------------------------------------------------------------------
// tmsm_ctrl
// sequencer for batch intake and the end-of-batch computation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tmsm_ctrl
    import tmsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       timed_out,
    output logic            s_tready,
    input  wire tmsm_stat_t stat,
    output tmsm_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   last_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = DIV_MV;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (timed_out)
                    begin
                        cmd.batch_clear = 1'b1;
                    end
                    else
                    begin
                        cmd.batch_add = 1'b1;
                        if (stat.last_sample)
                        begin
                            state_next = ST_MEAN;
                        end
                    end
                end
            end
            ST_MEAN:
            begin
                cmd.calc_mean = 1'b1;
                state_next    = ST_FILT;
            end
            ST_FILT:
            begin
                if (stat.seeded)
                begin
                    cmd.load_mix = 1'b1;
                    state_next   = ST_FILT_MUL;
                end
                else
                begin
                    cmd.load_filt_mean = 1'b1;
                    state_next         = ST_MV;
                end
            end
            ST_FILT_MUL:
            begin
                cmd.load_filt_div = 1'b1;
                state_next        = ST_MV;
            end
            ST_MV:
            begin
                if (stat.filt_zero)
                begin
                    cmd.load_mv_sat = 1'b1;
                    state_next      = ST_PCT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_MV;
                    state_next    = ST_MV_WAIT;
                end
            end
            ST_MV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.load_mv_div = 1'b1;
                    state_next      = ST_PCT;
                end
            end
            ST_PCT:
            begin
                if (stat.mv_le_empty)
                begin
                    cmd.load_pct_zero = 1'b1;
                    state_next        = ST_PUBLISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = DIV_PCT;
                    state_next    = ST_PCT_WAIT;
                end
            end
            ST_PCT_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.load_pct_div = 1'b1;
                    state_next       = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign last_accept = s_tvalid && s_tready && !timed_out && stat.last_sample;

    `TMSM_NEVER(a_start_while_busy, clk, rst_n, cmd.div_start && stat.div_busy, "divider restarted")
    `TMSM_ASSERT(a_publish_free, clk, rst_n, cmd.publish |-> stat.out_free, "result overwritten")
    `TMSM_ASSERT(a_last_to_mean, clk, rst_n, last_accept |=> state_reg == ST_MEAN, "batch end missed")

endmodule

`default_nettype wire

>>> hw/rtl/tmsm_dpath.sv
// ----------------------------------------------------------------------------
// tmsm_dpath
// batch accumulators, filter state, config registers, divider and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tmsm_dpath
    import tmsm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   cfg_we,
    input  wire cfg_addr_t              cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    input  wire tmsm_cmd_t              cmd,
    output tmsm_stat_t                  stat,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [SAMPLE_BITS-1:0]      filtered_reading,
    output logic [MV_W-1:0]             supply_millivolts,
    output logic [PCT_W-1:0]            charge_percent
);

    localparam int SUM_W  = SAMPLE_BITS + 4;
    localparam int PROD_W = SUM_W + FILT_RECIP_W;

    logic [SCALE_W-1:0]     vdd_scale_reg;
    logic [MV_W-1:0]        empty_mv_reg;
    logic [SPAN_W-1:0]      span_reg;

    logic [CNT_W-1:0]       cnt_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] prev_reg;

    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [SUM_W-1:0]       mix_reg;
    logic [SAMPLE_BITS-1:0] filt_reg;
    logic [MV_W-1:0]        mv_reg;
    logic [PCT_W-1:0]       pct_reg;

    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] out_filt_reg;
    logic [MV_W-1:0]        out_mv_reg;
    logic [PCT_W-1:0]       out_pct_reg;

    logic [SUM_W-1:0]       trimmed;
    logic [SUM_W-1:0]       mix_sum;
    logic [PROD_W-1:0]      filt_prod;
    logic [SAMPLE_BITS-1:0] filt_quo;
    logic [SPAN_W-1:0]      span_eff;
    logic [DIV_DEND_W-1:0]  div_dividend;
    logic [DIV_SOR_W-1:0]   div_divisor;
    logic                   div_busy;
    logic                   div_done;
    logic [DIV_DEND_W-1:0]  div_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vdd_scale_reg <= VDD_SCALE_RST;
            empty_mv_reg  <= EMPTY_MV_RST;
            span_reg      <= MV_PER_PCT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_VDD_SCALE:  vdd_scale_reg <= cfg_wdata[SCALE_W-1:0];
                CFG_EMPTY_MV:   empty_mv_reg  <= cfg_wdata[MV_W-1:0];
                CFG_MV_PER_PCT: span_reg      <= cfg_wdata[SPAN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            max_reg  <= '0;
            min_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            if (cmd.batch_clear || cmd.calc_mean)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                max_reg <= '0;
                min_reg <= '0;
            end
            else if (cmd.batch_add)
            begin
                if (cnt_reg == '0)
                begin
                    max_reg <= sample;
                    min_reg <= sample;
                end
                else if (sample > max_reg)
                begin
                    max_reg <= sample;
                end
                else if (sample < min_reg)
                begin
                    min_reg <= sample;
                end
                sum_reg <= sum_reg + SUM_W'(sample);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.load_filt_mean)
            begin
                prev_reg <= mean_reg;
            end
            else if (cmd.load_filt_div)
            begin
                prev_reg <= filt_quo;
            end
        end
    end

    always_comb
    begin
        trimmed   = sum_reg - SUM_W'(max_reg) - SUM_W'(min_reg);
        mix_sum   = SUM_W'(mean_reg) + (SUM_W'(mean_reg) << 1)
                  + (SUM_W'(prev_reg) << 3) - SUM_W'(prev_reg);
        filt_prod = PROD_W'(mix_reg) * PROD_W'(FILT_RECIP);
        filt_quo  = filt_prod[FILT_SHIFT +: SAMPLE_BITS];
        span_eff  = (span_reg == '0) ? SPAN_W'(1) : span_reg;
        case (cmd.div_op)
            DIV_MV:
            begin
                div_dividend = DIV_DEND_W'(vdd_scale_reg);
                div_divisor  = DIV_SOR_W'(filt_reg);
            end
            DIV_PCT:
            begin
                div_dividend = DIV_DEND_W'(mv_reg - empty_mv_reg);
                div_divisor  = DIV_SOR_W'(span_eff);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    tmsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.calc_mean)
        begin
            mean_reg <= trimmed[SAMPLE_BITS+2:3];
        end
        if (cmd.load_mix)
        begin
            mix_reg <= mix_sum;
        end
        if (cmd.load_filt_mean)
        begin
            filt_reg <= mean_reg;
        end
        else if (cmd.load_filt_div)
        begin
            filt_reg <= filt_quo;
        end
        if (cmd.load_mv_sat)
        begin
            mv_reg <= MV_MAX;
        end
        else if (cmd.load_mv_div)
        begin
            mv_reg <= (div_quo > DIV_DEND_W'(MV_MAX)) ? MV_MAX : div_quo[MV_W-1:0];
        end
        if (cmd.load_pct_zero)
        begin
            pct_reg <= '0;
        end
        else if (cmd.load_pct_div)
        begin
            pct_reg <= (div_quo > DIV_DEND_W'(PCT_MAX)) ? PCT_MAX : div_quo[PCT_W-1:0];
        end
        if (cmd.publish)
        begin
            out_filt_reg <= filt_reg;
            out_mv_reg   <= mv_reg;
            out_pct_reg  <= pct_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.last_sample = (cnt_reg == CNT_W'(BATCH_LEN - 1));
        stat.seeded      = (prev_reg != '0);
        stat.div_busy    = div_busy;
        stat.div_done    = div_done;
        stat.filt_zero   = (filt_reg == '0);
        stat.mv_le_empty = (mv_reg <= empty_mv_reg);
        stat.out_free    = ~m_tvalid_reg | m_tready;
    end

    assign m_tvalid          = m_tvalid_reg;
    assign filtered_reading  = out_filt_reg;
    assign supply_millivolts = out_mv_reg;
    assign charge_percent    = out_pct_reg;

    `TMSM_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(BATCH_LEN), "batch count overflow")
    `TMSM_ASSERT(a_pct_range, clk, rst_n, m_tvalid_reg |-> (out_pct_reg <= PCT_MAX), "percent above 100")
    `TMSM_NEVER(a_done_busy, clk, rst_n, div_done && div_busy, "divider done while still busy")

endmodule

`default_nettype wire

>>> hw/rtl/trimmed_mean_supply_monitor.sv
// ----------------------------------------------------------------------------
// trimmed_mean_supply_monitor
// bandgap batch averager with recursive filter, supply and charge estimate
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one bandgap conversion per transaction; s_tuser set
//   means the conversion timed out and the current batch is dropped
//   every tenth good conversion closes a batch and yields one transaction
//   on m_*: filtered reading, supply millivolts, charge percent
//   a conversion that does not close a batch leaves s_tready high for the next
//   the closing conversion runs the filter (a reciprocal multiply once the
//   filter is seeded), then up to two 24-step divisions in the restoring
//   divider; m_tvalid rises when the result is published to the output
//   register, and s_tready stays low from the closing transaction
//   until the result is in the output register
//   the output register holds one result; with m_tready low the block
//   keeps taking conversions until the next batch closes, then waits
//   cfg_we writes cfg_wdata into register cfg_addr:
//   0 vdd scale, 1 empty millivolts, 2 millivolts per percent
//   reset clears the batch, unseeds the filter, restores register defaults
//   and empties the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trimmed_mean_supply_monitor
    import tmsm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // conversion
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // timed_out
    input  wire logic                                  s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // filtered_reading, supply_millivolts, charge_percent
    output logic [((SAMPLE_BITS+MV_W+PCT_W+7)/8)*8-1:0] m_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [1:0]                            cfg_addr,
    input  wire logic [CFG_W-1:0]                      cfg_wdata
);

    localparam int OUT_W = ((SAMPLE_BITS + MV_W + PCT_W + 7) / 8) * 8;

    tmsm_cmd_t              cmd;
    tmsm_stat_t             stat;
    logic [SAMPLE_BITS-1:0] filtered_reading;
    logic [MV_W-1:0]        supply_millivolts;
    logic [PCT_W-1:0]       charge_percent;

    tmsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .timed_out (s_tuser),
        .s_tready  (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tmsm_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample            (s_tdata[SAMPLE_BITS-1:0]),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr_t'(cfg_addr)),
        .cfg_wdata         (cfg_wdata),
        .cmd               (cmd),
        .stat              (stat),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .filtered_reading  (filtered_reading),
        .supply_millivolts (supply_millivolts),
        .charge_percent    (charge_percent)
    );

    assign m_tdata = OUT_W'({charge_percent, supply_millivolts, filtered_reading});

endmodule

`default_nettype wire
